[design/sfspc_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper full-step controller package
// Shared types, register codes, limits and the coil pattern table.
// ----------------------------------------------------------------------------
`default_nettype none

package sfspc_pkg;

    localparam int POS_WIDTH_DEF = 16;

    localparam logic [15:0] PERIOD_MIN   = 16'd100;
    localparam logic [15:0] PERIOD_MAX   = 16'd60000;
    localparam logic [15:0] PERIOD_RESET = 16'd3000;
    localparam logic [15:0] LIMIT_RESET  = 16'd4096;

    typedef enum logic [2:0] {
        FUNC_TICK       = 3'd0,
        FUNC_MOVE       = 3'd1,
        FUNC_OPEN       = 3'd2,
        FUNC_CLOSE      = 3'd3,
        FUNC_ABORT      = 3'd4,
        FUNC_FORCE_OPEN = 3'd5,
        FUNC_RELEASE    = 3'd6
    } t_func;

    typedef enum logic {
        REG_STEP_PERIOD  = 1'b0,
        REG_TRAVEL_LIMIT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [3:0]  coils;
        logic [15:0] position;
        logic [15:0] steps_remaining;
        logic        moving;
        logic        fully_open;
        logic        accepted;
        logic        stepped;
    } t_result;

    function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'h3;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'hC;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

[design/sfspc_if.sv]
// ----------------------------------------------------------------------------
// Stepper full-step controller channels
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfspc_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [16:0] steps;

    modport source (output valid, output func, output steps, input ready);
    modport sink   (input valid, input func, input steps, output ready);
endinterface

interface sfspc_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  coils;
    logic [15:0] position;
    logic [15:0] steps_remaining;
    logic        moving;
    logic        fully_open;
    logic        accepted;
    logic        stepped;

    modport source (output valid, output coils, output position, output steps_remaining,
                    output moving, output fully_open, output accepted, output stepped,
                    input ready);
    modport sink   (input valid, input coils, input position, input steps_remaining,
                    input moving, input fully_open, input accepted, input stepped,
                    output ready);
endinterface

interface sfspc_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/sfspc_core.sv]
// ----------------------------------------------------------------------------
// Stepper full-step controller core
// Holds the motion state and computes the update and result for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module sfspc_core
    import sfspc_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire logic [2:0]         i_func,
    input  wire logic signed [16:0] i_steps,
    input  wire logic [15:0]        i_period,
    input  wire logic [15:0]        i_limit,
    output t_result                 o_result
);

    localparam int WW = (POS_WIDTH > 16) ? POS_WIDTH : 16;
    localparam logic [WW-1:0] POS_MAX = WW'((64'd1 << POS_WIDTH) - 64'd1);

    logic [1:0]           r_phase, n_phase;
    logic [3:0]           r_coils, n_coils;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [15:0]          r_left, n_left;
    logic                 r_dir, n_dir;
    logic [15:0]          r_tick, n_tick;
    logic                 r_run, n_run;
    logic [15:0]          r_aper, n_aper;

    logic [WW-1:0] lim_w;
    logic [WW-1:0] pos_w;
    logic [WW-1:0] st_pos_w;
    logic [WW-1:0] n_pos_w;
    logic [1:0]    st_phase;
    logic [15:0]   st_left;
    logic [15:0]   tick_inc;
    logic [15:0]   open_n;
    logic [15:0]   close_n;
    logic [16:0]   steps_u;
    logic [16:0]   mag17;
    logic [15:0]   mag16;
    logic          neg;
    logic          acc;
    logic          stp;

    always_comb begin
        lim_w = (WW'(i_limit) < POS_MAX) ? WW'(i_limit) : POS_MAX;
        pos_w = WW'(r_pos);
        open_n = 16'(lim_w - pos_w);
        close_n = (pos_w > WW'(16'hFFFF)) ? 16'hFFFF : pos_w[15:0];
        tick_inc = r_tick + 16'd1;
        steps_u = $unsigned(i_steps);
        neg = steps_u[16];
        mag17 = neg ? (17'd0 - steps_u) : steps_u;
        mag16 = mag17[16] ? 16'hFFFF : mag17[15:0];
    end

    always_comb begin
        st_pos_w = pos_w;
        if (r_dir) begin
            st_phase = r_phase + 2'd1;
            if (pos_w < lim_w) begin
                st_pos_w = pos_w + WW'(1);
            end
        end else begin
            st_phase = r_phase - 2'd1;
            if (pos_w != '0) begin
                st_pos_w = pos_w - WW'(1);
            end
        end
        if (st_pos_w > lim_w) begin
            st_pos_w = lim_w;
        end
        st_left = (r_left != 16'd0) ? (r_left - 16'd1) : 16'd0;
    end

    always_comb begin
        n_phase = r_phase;
        n_coils = r_coils;
        n_pos   = r_pos;
        n_left  = r_left;
        n_dir   = r_dir;
        n_tick  = r_tick;
        n_run   = r_run;
        n_aper  = r_aper;
        acc     = 1'b0;
        stp     = 1'b0;
        case (t_func'(i_func)) inside
            FUNC_TICK: begin
                if (r_run) begin
                    n_tick = tick_inc;
                    if (tick_inc >= r_aper) begin
                        n_tick  = 16'd0;
                        n_phase = st_phase;
                        n_pos   = POS_WIDTH'(st_pos_w);
                        n_coils = coil_pattern(st_phase);
                        n_left  = st_left;
                        if (st_left == 16'd0) begin
                            n_run = 1'b0;
                        end
                        stp = 1'b1;
                    end
                end
            end
            FUNC_MOVE: begin
                if (!r_run && mag16 != 16'd0) begin
                    n_dir  = !neg;
                    n_left = mag16;
                    n_tick = 16'd0;
                    n_aper = i_period;
                    n_run  = 1'b1;
                    acc    = 1'b1;
                end
            end
            FUNC_OPEN: begin
                if (!r_run && pos_w < lim_w) begin
                    n_dir  = 1'b1;
                    n_left = open_n;
                    n_tick = 16'd0;
                    n_aper = i_period;
                    n_run  = 1'b1;
                    acc    = 1'b1;
                end
            end
            FUNC_CLOSE: begin
                if (!r_run && pos_w != '0) begin
                    n_dir  = 1'b0;
                    n_left = close_n;
                    n_tick = 16'd0;
                    n_aper = i_period;
                    n_run  = 1'b1;
                    acc    = 1'b1;
                end
            end
            FUNC_ABORT, FUNC_FORCE_OPEN: begin
                acc    = r_run;
                n_run  = 1'b0;
                n_left = 16'd0;
                n_tick = 16'd0;
                if (t_func'(i_func) == FUNC_FORCE_OPEN && pos_w < lim_w) begin
                    n_dir  = 1'b1;
                    n_left = open_n;
                    n_aper = i_period;
                    n_run  = 1'b1;
                    acc    = 1'b1;
                end
            end
            FUNC_RELEASE: begin
                n_coils = 4'h0;
                acc     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_coils <= 4'h0;
            r_pos   <= '0;
            r_left  <= 16'd0;
            r_dir   <= 1'b0;
            r_tick  <= 16'd0;
            r_run   <= 1'b0;
            r_aper  <= PERIOD_RESET;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_coils <= n_coils;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_dir   <= n_dir;
            r_tick  <= n_tick;
            r_run   <= n_run;
            r_aper  <= n_aper;
        end
    end

    always_comb begin
        n_pos_w                  = WW'(n_pos);
        o_result.coils           = n_coils;
        o_result.position        = n_pos_w[15:0];
        o_result.steps_remaining = n_left;
        o_result.moving          = n_run;
        o_result.fully_open      = (n_pos_w >= lim_w);
        o_result.accepted        = acc;
        o_result.stepped         = stp;
    end

endmodule

`default_nettype wire

[design/stepper_full_step_position_controller.sv]
// ----------------------------------------------------------------------------
// Stepper full-step position controller
// Full-step sequencer with position tracking for a four-coil stepper motor.
//
// The command channel carries one tick or one command per transfer. Every
// accepted transfer produces exactly one transfer on the result channel,
// carrying the coil pattern, position and move status after the update.
// The configuration channel writes the step period (index 0) and the travel
// limit (index 1); it is always ready and should be used while idle.
//
// A command's result is registered. A new command can be taken every cycle
// while the skid entry is empty. Results sit in an output register backed
// by one skid entry, so a command is still taken while one result waits;
// the command channel drops ready only while both hold results.
// Reset clears the motion state, turns the coils off, empties the output
// stage and loads a 3000 tick period and a 4096 step limit.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_full_step_position_controller
    import sfspc_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sfspc_cmd_if.sink    i_cmd,
    sfspc_res_if.source  o_res,
    sfspc_cfg_if.sink    i_cfg
);

    logic [15:0] r_period;
    logic [15:0] r_limit;
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    t_result     core_result;
    logic        cmd_fire;
    logic        out_fire;
    logic        cfg_fire;
    logic [15:0] period_sat;

    assign i_cmd.ready = !r_skid_valid;
    assign i_cfg.ready = 1'b1;
    assign cmd_fire    = i_cmd.valid && !r_skid_valid;
    assign out_fire    = r_out_valid && o_res.ready;
    assign cfg_fire    = i_cfg.valid;

    always_comb begin
        if (i_cfg.data < PERIOD_MIN) begin
            period_sat = PERIOD_MIN;
        end else if (i_cfg.data > PERIOD_MAX) begin
            period_sat = PERIOD_MAX;
        end else begin
            period_sat = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_limit  <= LIMIT_RESET;
        end else if (cfg_fire) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_STEP_PERIOD:  r_period <= period_sat;
                REG_TRAVEL_LIMIT: r_limit  <= (i_cfg.data == 16'd0) ? 16'd1 : i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    sfspc_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (cmd_fire),
        .i_func   (i_cmd.func),
        .i_steps  (i_cmd.steps),
        .i_period (r_period),
        .i_limit  (r_limit),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (cmd_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (cmd_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= core_result;
            end else begin
                r_out <= core_result;
            end
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.coils           = r_out.coils;
    assign o_res.position        = r_out.position;
    assign o_res.steps_remaining = r_out.steps_remaining;
    assign o_res.moving          = r_out.moving;
    assign o_res.fully_open      = r_out.fully_open;
    assign o_res.accepted        = r_out.accepted;
    assign o_res.stepped         = r_out.stepped;

endmodule

`default_nettype wire

[tb/sv/stepper_full_step_position_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper full-step position controller testbench
// Drives ticks and motion commands with random gaps on both channels,
// predicts every result from its own copy of the motor state and checks
// each result transfer field by field, over several register settings.
// ----------------------------------------------------------------------------

module stepper_full_step_position_controller_tb;
    import sfspc_pkg::*;

    localparam logic [2:0]  FUNC_UNUSED     = 3'd7;
    localparam logic [15:0] FULL_STEP_SEQ   = 16'h9C63;
    localparam int          ITEMS_PER_PHASE = 25;

    typedef struct packed {
        logic [2:0]  func;
        logic [16:0] steps;
    } t_cmd_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfspc_cmd_if cmd_if ();
    sfspc_res_if res_if ();
    sfspc_cfg_if cfg_if ();

    stepper_full_step_position_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_cmd_item   cmd_backlog[$];
    t_result     status_due[$];
    t_cmd_item   next_cmd;
    t_result     want;

    logic [1:0]  mtr_phase      = 2'd0;
    logic [3:0]  mtr_coils      = 4'h0;
    logic [15:0] mtr_pos        = 16'd0;
    logic [15:0] mtr_left       = 16'd0;
    logic        mtr_up         = 1'b0;
    logic [15:0] mtr_ticks      = 16'd0;
    logic        mtr_run        = 1'b0;
    logic [15:0] mtr_period_run = PERIOD_RESET;
    logic [15:0] reg_period     = PERIOD_RESET;
    logic [15:0] reg_limit      = LIMIT_RESET;

    bit cmd_took = 1'b0;
    bit res_took = 1'b0;
    bit cfg_took = 1'b0;
    bit cmd_live = 1'b0;
    int cmd_gap  = 0;
    int cmd_calm = 0;
    int res_wait = 0;
    int res_calm = 0;

    int fail_count = 0;
    int res_index  = 0;
    int n_cmds     = 0;
    int n_ticks    = 0;
    int n_steps    = 0;
    int n_cfg      = 0;

    task automatic report_error(input string msg);
        fail_count++;
        if (fail_count <= 40) begin
            $display("ERROR: %s", msg);
        end
    endtask

    function automatic void start_move(input logic up, input logic [15:0] n);
        mtr_up         = up;
        mtr_left       = n;
        mtr_ticks      = 16'd0;
        mtr_period_run = reg_period;
        mtr_run        = 1'b1;
    endfunction

    function automatic bit try_open();
        if (mtr_pos >= reg_limit) begin
            return 1'b0;
        end
        start_move(1'b1, reg_limit - mtr_pos);
        return 1'b1;
    endfunction

    function automatic void take_full_step();
        if (mtr_up) begin
            mtr_phase = mtr_phase + 2'd1;
            if (mtr_pos < reg_limit) mtr_pos = mtr_pos + 16'd1;
        end else begin
            mtr_phase = mtr_phase - 2'd1;
            if (mtr_pos != 16'd0) mtr_pos = mtr_pos - 16'd1;
        end
        if (mtr_pos > reg_limit) mtr_pos = reg_limit;
        mtr_coils = FULL_STEP_SEQ[mtr_phase * 4 +: 4];
        if (mtr_left != 16'd0) mtr_left = mtr_left - 16'd1;
        if (mtr_left == 16'd0) mtr_run = 1'b0;
    endfunction

    task automatic predict_status(input logic [2:0] fn, input logic [16:0] raw,
                                  output t_result r);
        logic        ok;
        logic        took_step;
        logic [16:0] mag;
        ok        = 1'b0;
        took_step = 1'b0;
        case (fn)
            FUNC_TICK: begin
                if (mtr_run) begin
                    mtr_ticks = mtr_ticks + 16'd1;
                    if (mtr_ticks >= mtr_period_run) begin
                        mtr_ticks = 16'd0;
                        take_full_step();
                        took_step = 1'b1;
                    end
                end
            end
            FUNC_MOVE: begin
                if (!mtr_run) begin
                    mag = raw[16] ? (17'd0 - raw) : raw;
                    if (mag > 17'h0FFFF) mag = 17'h0FFFF;
                    if (mag != 17'd0) begin
                        start_move(!raw[16], mag[15:0]);
                        ok = 1'b1;
                    end
                end
            end
            FUNC_OPEN: begin
                if (!mtr_run) ok = try_open();
            end
            FUNC_CLOSE: begin
                if (!mtr_run && mtr_pos != 16'd0) begin
                    start_move(1'b0, mtr_pos);
                    ok = 1'b1;
                end
            end
            FUNC_ABORT, FUNC_FORCE_OPEN: begin
                ok        = mtr_run;
                mtr_run   = 1'b0;
                mtr_left  = 16'd0;
                mtr_ticks = 16'd0;
                if (fn == FUNC_FORCE_OPEN && try_open()) ok = 1'b1;
            end
            FUNC_RELEASE: begin
                mtr_coils = 4'h0;
                ok        = 1'b1;
            end
            default: begin
            end
        endcase
        r.coils           = mtr_coils;
        r.position        = mtr_pos;
        r.steps_remaining = mtr_left;
        r.moving          = mtr_run;
        r.fully_open      = (mtr_pos >= reg_limit);
        r.accepted        = ok;
        r.stepped         = took_step;
    endtask

    task automatic draw_wait(inout int calm, output int cycles);
        if (calm > 0) begin
            calm--;
            cycles = 0;
        end else if ($urandom_range(0, 29) == 0) begin
            calm   = int'($urandom_range(20, 60));
            cycles = 0;
        end else begin
            cycles = int'($urandom_range(0, 9));
        end
    endtask

    // Sampling, checking and prediction all happen at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_took = 1'b0;
            res_took = 1'b0;
            cfg_took = 1'b0;
        end else begin
            cmd_took = cmd_if.valid && cmd_if.ready;
            res_took = res_if.valid && res_if.ready;
            cfg_took = cfg_if.valid && cfg_if.ready;
            if (res_took) begin
                res_index++;
                if (res_if.stepped === 1'b1) n_steps++;
                if (status_due.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           res_index));
                end else begin
                    want = status_due.pop_front();
                    if (res_if.coils !== want.coils)
                        report_error($sformatf("result %0d coils: got %h, expected %h",
                                               res_index, res_if.coils, want.coils));
                    if (res_if.position !== want.position)
                        report_error($sformatf("result %0d position: got %0d, expected %0d",
                                               res_index, res_if.position, want.position));
                    if (res_if.steps_remaining !== want.steps_remaining)
                        report_error($sformatf("result %0d steps_remaining: got %0d, expected %0d",
                                               res_index, res_if.steps_remaining,
                                               want.steps_remaining));
                    if (res_if.moving !== want.moving)
                        report_error($sformatf("result %0d moving: got %b, expected %b",
                                               res_index, res_if.moving, want.moving));
                    if (res_if.fully_open !== want.fully_open)
                        report_error($sformatf("result %0d fully_open: got %b, expected %b",
                                               res_index, res_if.fully_open, want.fully_open));
                    if (res_if.accepted !== want.accepted)
                        report_error($sformatf("result %0d accepted: got %b, expected %b",
                                               res_index, res_if.accepted, want.accepted));
                    if (res_if.stepped !== want.stepped)
                        report_error($sformatf("result %0d stepped: got %b, expected %b",
                                               res_index, res_if.stepped, want.stepped));
                end
            end
            if (cfg_took) begin
                n_cfg++;
                if (cfg_if.index == REG_STEP_PERIOD) begin
                    if (cfg_if.data < PERIOD_MIN) reg_period = PERIOD_MIN;
                    else if (cfg_if.data > PERIOD_MAX) reg_period = PERIOD_MAX;
                    else reg_period = cfg_if.data;
                end else begin
                    reg_limit = (cfg_if.data == 16'd0) ? 16'd1 : cfg_if.data;
                end
            end
            if (cmd_took) begin
                if (cmd_if.func == FUNC_TICK) n_ticks++;
                else n_cmds++;
                predict_status(cmd_if.func, cmd_if.steps, want);
                status_due.push_back(want);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            cmd_live = 1'b0;
        end else if (!cmd_if.valid || cmd_took) begin
            if (cmd_gap > 0) begin
                cmd_if.valid <= 1'b0;
                cmd_live = 1'b0;
                cmd_gap--;
            end else if (cmd_backlog.size() > 0) begin
                next_cmd = cmd_backlog.pop_front();
                cmd_if.valid <= 1'b1;
                cmd_if.func  <= next_cmd.func;
                cmd_if.steps <= next_cmd.steps;
                cmd_live = 1'b1;
                draw_wait(cmd_calm, cmd_gap);
            end else begin
                cmd_if.valid <= 1'b0;
                cmd_live = 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (res_took) draw_wait(res_calm, res_wait);
        if (res_wait > 0) begin
            res_if.ready <= 1'b0;
            res_wait--;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    task automatic queue_cmd(input logic [2:0] fn, input logic [16:0] st);
        t_cmd_item item;
        item.func  = fn;
        item.steps = st;
        cmd_backlog.push_back(item);
    endtask

    task automatic queue_ticks(input int n);
        logic [16:0] junk;
        for (int i = 0; i < n; i++) begin
            junk = 17'($urandom);
            queue_cmd(FUNC_TICK, junk);
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(negedge i_clk); while (!cfg_took);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || cmd_live || status_due.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Random single commands mixed with motion commands, each of the latter
    // followed by a tick train sized to the period and to what is left of the
    // budget, sometimes cut by a second command.
    task automatic queue_random_phase(input int budget);
        int          made;
        int          per;
        int          n;
        int          cut;
        logic [16:0] amt;
        logic [16:0] rnd;
        logic [2:0]  fn;
        made = 0;
        per  = int'(reg_period);
        while (made < budget) begin
            rnd = 17'($urandom);
            if ($urandom_range(0, 99) < 40) begin
                fn = 3'($urandom_range(0, 7));
                queue_cmd(fn, rnd);
                made++;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        if ($urandom_range(0, 4) == 0) begin
                            amt = rnd;
                        end else begin
                            amt = 17'($urandom_range(1, 4));
                            if ($urandom_range(0, 1) == 1) amt = 17'd0 - amt;
                        end
                        queue_cmd(FUNC_MOVE, amt);
                    end
                    5, 6:    queue_cmd(FUNC_OPEN, rnd);
                    7, 8:    queue_cmd(FUNC_CLOSE, rnd);
                    default: queue_cmd(FUNC_FORCE_OPEN, rnd);
                endcase
                made++;
                n = per + int'($urandom_range(0, per));
                if (n > 300) n = int'($urandom_range(20, 300));
                if (n > budget - made) n = budget - made;
                cut = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, n)) : -1;
                for (int i = 0; i < n; i++) begin
                    if (i == cut) begin
                        fn  = 3'($urandom_range(1, 6));
                        rnd = 17'($urandom);
                        queue_cmd(fn, rnd);
                        made++;
                    end
                    queue_ticks(1);
                    made++;
                end
            end
        end
    endtask

    initial begin
        logic [15:0] per_val;
        logic [15:0] lim_val;
        cmd_if.valid = 1'b0;
        cmd_if.func  = FUNC_TICK;
        cmd_if.steps = 17'd0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_STEP_PERIOD;
        cfg_if.data  = 16'd0;
        res_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(REG_STEP_PERIOD, 16'd0);
        write_reg(REG_TRAVEL_LIMIT, 16'd3);
        queue_ticks(1);
        queue_cmd(FUNC_UNUSED, 17'h1FFFF);
        queue_cmd(FUNC_MOVE, 17'd0);
        queue_cmd(FUNC_CLOSE, 17'd0);
        queue_cmd(FUNC_ABORT, 17'd0);
        queue_cmd(FUNC_RELEASE, 17'd0);
        queue_cmd(FUNC_MOVE, 17'd2);
        queue_cmd(FUNC_MOVE, 17'd1);
        queue_cmd(FUNC_OPEN, 17'd0);
        queue_cmd(FUNC_CLOSE, 17'd0);
        queue_ticks(200);
        queue_cmd(FUNC_OPEN, 17'd0);
        queue_ticks(100);
        queue_cmd(FUNC_OPEN, 17'd0);
        queue_cmd(FUNC_FORCE_OPEN, 17'd0);
        queue_cmd(FUNC_MOVE, 17'h10000);
        queue_ticks(200);
        queue_cmd(FUNC_ABORT, 17'd0);
        queue_cmd(FUNC_FORCE_OPEN, 17'd0);
        queue_ticks(50);
        queue_cmd(FUNC_FORCE_OPEN, 17'd0);
        queue_cmd(FUNC_RELEASE, 17'd0);
        queue_ticks(100);
        queue_cmd(FUNC_ABORT, 17'd0);
        queue_cmd(FUNC_MOVE, 17'h0FFFF);
        queue_ticks(10);
        queue_cmd(FUNC_ABORT, 17'd0);
        wait_idle();

        // Lower the limit under the position while a move is running.
        write_reg(REG_STEP_PERIOD, 16'd99);
        write_reg(REG_TRAVEL_LIMIT, 16'd65535);
        queue_cmd(FUNC_MOVE, 17'd2);
        queue_ticks(220);
        queue_cmd(FUNC_MOVE, 17'd3);
        queue_ticks(50);
        wait_idle();
        write_reg(REG_TRAVEL_LIMIT, 16'd1);
        queue_ticks(40);
        queue_ticks(20);
        queue_cmd(FUNC_FORCE_OPEN, 17'd0);
        queue_cmd(FUNC_ABORT, 17'd0);
        queue_cmd(FUNC_OPEN, 17'd0);
        queue_cmd(FUNC_CLOSE, 17'd0);
        queue_ticks(30);
        queue_cmd(FUNC_ABORT, 17'd0);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin per_val = 16'd100;   lim_val = 16'd1;     end
                1: begin
                    per_val = 16'd100 + 16'($urandom_range(0, 60));
                    lim_val = 16'($urandom_range(2, 12));
                end
                2: begin per_val = 16'd65535; lim_val = 16'd65535; end
                3: begin per_val = 16'd100;   lim_val = 16'($urandom_range(3, 8)); end
                4: begin per_val = 16'($urandom_range(0, 65535)); lim_val = LIMIT_RESET; end
                5: begin per_val = 16'd101;   lim_val = 16'd65535; end
                6: begin per_val = 16'd60000; lim_val = 16'd0;     end
                default: begin per_val = 16'd100; lim_val = 16'($urandom_range(1, 20)); end
            endcase
            write_reg(REG_STEP_PERIOD, per_val);
            write_reg(REG_TRAVEL_LIMIT, lim_val);
            queue_random_phase(ITEMS_PER_PHASE);
            wait_idle();
        end

        repeat (5) @(negedge i_clk);
        if (status_due.size() != 0)
            report_error($sformatf("%0d expected results never arrived", status_due.size()));
        $display("Run covered %0d commands, %0d ticks and %0d motor steps over %0d register writes.",
                 n_cmds, n_ticks, n_steps, n_cfg);
        if (fail_count == 0) begin
            $display("stepper_full_step_position_controller_tb: PASS");
        end else begin
            $display("%0d mismatches found.", fail_count);
            $display("stepper_full_step_position_controller_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Run timed out.");
        $display("stepper_full_step_position_controller_tb: FAIL");
        $finish;
    end

endmodule
